FILE: src/bbfc_pkg.sv
// bbfc_pkg: shared types and constants for the buddy free/coalesce block.
// Item structs, field widths and page-row geometry. No dependencies.
`default_nettype none

package bbfc_pkg;

    localparam int START_W        = 10;   // block_start / merged_start width
    localparam int ORDER_W        = 4;    // block_order / merged_order width
    localparam int ROW_SH         = 5;    // log2 of pages per in-use row
    localparam int ROW_W          = 1 << ROW_SH;
    localparam int PAGE_COUNT_DEF = 1024;
    localparam int TOP_ORDER_DEF  = 10;

    typedef struct packed {
        logic [START_W-1:0] block_start;
        logic [ORDER_W-1:0] block_order;
    } in_item_t;

    typedef struct packed {
        logic [START_W-1:0] merged_start;
        logic [ORDER_W-1:0] merged_order;
    } out_item_t;

endpackage

`default_nettype wire

FILE: src/bbfc_span_mask.sv
// bbfc_span_mask: per-row clear mask for a page span [first, last].
// Uses bbfc_pkg for row geometry.
`default_nettype none

module bbfc_span_mask
    import bbfc_pkg::*;
#(
    parameter int PW = 10,
    parameter int RW = 5
) (
    input  wire logic [RW-1:0]    row,
    input  wire logic [PW-1:0]    first,
    input  wire logic [PW-1:0]    last,
    output logic      [ROW_W-1:0] mask
);

    localparam int GW = (RW + ROW_SH > PW) ? RW + ROW_SH : PW;

    always_comb begin
        logic [GW-1:0] page;
        for (int b = 0; b < ROW_W; b++) begin
            page    = GW'({row, ROW_SH'(b)});
            mask[b] = (page >= GW'(first)) && (page <= GW'(last));
        end
    end

endmodule

`default_nettype wire

FILE: src/buddy_block_free_coalesce.sv
// buddy_block_free_coalesce: buddy free path with coalescing; needs bbfc_pkg, bbfc_span_mask.
// Per item: accept; for a start inside the table, clear the freed span's in-use rows and probe the
// buddy, merging while it is free at the same order (a probe stopped by the order limit or table
// end skips the check); then post the result. Throughput: one item at a time, s_ready only while
// idle; done waits on an unaccepted result. Reset (aresetn, sync, active low): a sweep marks every
// page used and zeroes every head order; no item is accepted during the sweep.
`default_nettype none

module buddy_block_free_coalesce
    import bbfc_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF,
    parameter int TOP_ORDER  = TOP_ORDER_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_payload
);

    // Widths derived from the table size and order limit.
    localparam int PW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;      // page address
    localparam int ROWS = (PAGE_COUNT + ROW_W - 1) / ROW_W;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;                  // row address
    localparam int OWT  = $clog2(TOP_ORDER + 1);
    localparam int OW   = (OWT > ORDER_W) ? OWT : ORDER_W;                // working order
    localparam int SW   = (PW > START_W) ? PW : START_W;                  // working start
    localparam int BW   = (SW > TOP_ORDER) ? SW : TOP_ORDER;              // buddy index
    localparam int EW   = BW + 1;                                         // span end

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,   // post-reset sweep over both tables
        ST_IDLE  = 6'b000010,   // waiting for an item
        ST_CLEAR = 6'b000100,   // clearing in-use bits, one row per cycle
        ST_PROBE = 6'b001000,   // compute buddy, issue table reads
        ST_CHECK = 6'b010000,   // test buddy, merge on a match
        ST_DONE  = 6'b100000    // hand result to the output register
    } state_t;

    // Page tables: in-use bits kept as 32-page rows so a span clears a row per cycle;
    // head orders one entry per page.
    logic [ROW_W-1:0]   use_mem  [ROWS];
    logic [ORDER_W-1:0] size_mem [PAGE_COUNT];

    state_t             state_reg, state_next;
    logic [PW-1:0]      init_reg;
    logic [SW-1:0]      cur_start_reg;
    logic [OW-1:0]      order_reg;
    logic [PW-1:0]      first_reg, last_reg;
    logic [RW-1:0]      row_reg, last_row_reg;
    logic [PW-1:0]      buddy_reg;
    logic [ROW_SH-1:0]  col_reg;
    logic [ROW_W-1:0]   rd_row_reg;
    logic [ORDER_W-1:0] rd_ord_reg;
    logic               m_valid_reg;
    out_item_t          out_reg;

    logic               s_fire;
    logic [OW-1:0]      ord_in;
    logic               start_in_table;
    logic [EW-1:0]      end_w;
    logic [PW-1:0]      last_w;
    logic [BW-1:0]      buddy_w;
    logic               buddy_in_table;
    logic               can_grow;
    logic               merge_ok;
    logic [SW-1:0]      new_start;
    logic [ROW_W-1:0]   clear_mask;

    logic               size_we;
    logic [PW-1:0]      size_addr;
    logic [ORDER_W-1:0] size_data;
    logic               use_we;
    logic [RW-1:0]      use_addr;
    logic [ROW_W-1:0]   use_mask;
    logic               use_val;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // Input decode: saturate order, range-check start, find last page inside the table.
    assign ord_in = (OW'(s_payload.block_order) > OW'(TOP_ORDER))
                    ? OW'(TOP_ORDER) : OW'(s_payload.block_order);
    assign start_in_table = 32'(s_payload.block_start) < 32'(PAGE_COUNT);
    assign end_w  = EW'(s_payload.block_start) + (EW'(1) << ord_in) - EW'(1);
    assign last_w = (end_w >= EW'(PAGE_COUNT)) ? PW'(PAGE_COUNT - 1) : PW'(end_w);

    // Shared buddy unit: xor, range compare, order limit.
    assign buddy_w        = BW'(cur_start_reg) ^ (BW'(1) << order_reg);
    assign buddy_in_table = {1'b0, buddy_w} < (BW + 1)'(PAGE_COUNT);
    assign can_grow       = order_reg < OW'(TOP_ORDER);
    assign merge_ok       = !rd_row_reg[col_reg] && (OW'(rd_ord_reg) == order_reg);
    assign new_start      = cur_start_reg & SW'(buddy_reg);   // start with bit 'order' cleared

    bbfc_span_mask #(
        .PW (PW),
        .RW (RW)
    ) u_span_mask (
        .row   (row_reg),
        .first (first_reg),
        .last  (last_reg),
        .mask  (clear_mask)
    );

    // Table write port selection.
    always_comb begin
        size_we   = 1'b0;
        size_addr = init_reg;
        size_data = '0;
        use_we    = 1'b0;
        use_addr  = RW'(init_reg >> ROW_SH);
        use_mask  = '1;
        use_val   = 1'b1;
        unique case (state_reg) inside
            ST_INIT: begin
                size_we = 1'b1;
                use_we  = 1'b1;
            end
            ST_IDLE: begin
                // new head takes the freed order
                size_we   = s_fire && start_in_table;
                size_addr = PW'(s_payload.block_start);
                size_data = ORDER_W'(ord_in);
            end
            ST_CLEAR: begin
                use_we   = 1'b1;
                use_addr = row_reg;
                use_mask = clear_mask;
                use_val  = 1'b0;
            end
            ST_CHECK: begin
                // merged head gets order + 1
                size_we   = merge_ok;
                size_addr = PW'(new_start);
                size_data = ORDER_W'(order_reg + OW'(1));
            end
            ST_PROBE, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_addr] <= size_data;
        end
        if (use_we) begin
            for (int b = 0; b < ROW_W; b++) begin
                if (use_mask[b]) begin
                    use_mem[use_addr][b] <= use_val;
                end
            end
        end
        if (state_reg == ST_PROBE) begin
            rd_row_reg <= use_mem[RW'(PW'(buddy_w) >> ROW_SH)];
            rd_ord_reg <= size_mem[PW'(buddy_w)];
        end
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (init_reg == PW'(PAGE_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = start_in_table ? ST_CLEAR : ST_DONE;
                end
            end
            ST_CLEAR: begin
                if (row_reg == last_row_reg) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                state_next = (can_grow && buddy_in_table) ? ST_CHECK : ST_DONE;
            end
            ST_CHECK: begin
                state_next = merge_ok ? ST_PROBE : ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            init_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INIT) begin
                init_reg <= init_reg + PW'(1);
            end
            if (state_reg == ST_DONE && !m_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers (no reset needed).
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cur_start_reg <= SW'(s_payload.block_start);
                    order_reg     <= ord_in;
                    first_reg     <= PW'(s_payload.block_start);
                    last_reg      <= last_w;
                    row_reg       <= RW'(s_payload.block_start >> ROW_SH);
                    last_row_reg  <= RW'(last_w >> ROW_SH);
                end
            end
            ST_CLEAR: begin
                row_reg <= row_reg + RW'(1);
            end
            ST_PROBE: begin
                buddy_reg <= PW'(buddy_w);
                col_reg   <= ROW_SH'(buddy_w);
            end
            ST_CHECK: begin
                if (merge_ok) begin
                    cur_start_reg <= new_start;
                    order_reg     <= order_reg + OW'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg) begin
                    out_reg.merged_start <= START_W'(cur_start_reg);
                    out_reg.merged_order <= ORDER_W'(order_reg);
                end
            end
            ST_INIT: begin
            end
            default: begin
            end
        endcase
    end

    // A merge raises the order by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && merge_ok) |=> (order_reg == $past(order_reg) + OW'(1)))
        else $error("merge did not raise order by one");

    // Order never passes the limit while an item is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE || state_reg == ST_CHECK) |-> (order_reg <= OW'(TOP_ORDER)))
        else $error("order above limit");

    // Row sweep stays within the span.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (row_reg <= last_row_reg))
        else $error("clear row past span end");

    // A finished item posts its result and the sequencer goes back to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !m_valid_reg) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not posted on completion");

endmodule

`default_nettype wire
